>>> rtl/core/soft_timer_bank_assert.svh
// Assertion macros shared by the timer bank RTL.
// Each macro checks one implication on the rising edge of i_clk and is
// disabled while i_rst_n is low.
`ifndef SOFT_TIMER_BANK_ASSERT_SVH
`define SOFT_TIMER_BANK_ASSERT_SVH

// Same-cycle implication.
`define STB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define STB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/stb_pkg.sv
package stb_pkg;

    localparam int OPCODE_W  = 3;
    localparam int ID_W      = 8;
    localparam int PERIOD_W  = 32;
    localparam int RUN_W     = 31;

    // Run-time counter wraps to zero when it would reach this value
    localparam logic [RUN_W-1:0] RUN_TIME_WRAP = 31'h7FFF_FFFF;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK       = 3'd0,
        OP_START_ONCE = 3'd1,
        OP_START_AUTO = 3'd2,
        OP_STOP       = 3'd3,
        OP_CHECK      = 3'd4,
        OP_READ_TIME  = 3'd5,
        OP_ELAPSED    = 3'd6
    } t_opcode;

    // Broadcast to all cells; start/stop/check need the cell select
    typedef struct packed {
        logic                tick;
        logic                start;
        logic                auto_reload;
        logic                stop;
        logic                check;
        logic [PERIOD_W-1:0] period;
    } t_cell_cmd;

endpackage

>>> rtl/core/stb_timer_cell.sv
module stb_timer_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stb_pkg::t_cell_cmd i_cmd,
    input  logic              i_sel,
    output logic              o_flag
);
    import stb_pkg::*;

    logic [PERIOD_W-1:0] r_remaining, n_remaining;
    logic [PERIOD_W-1:0] r_reload, n_reload;
    logic                r_flag, n_flag;
    logic                r_auto, n_auto;

    // Count down on tick, or apply start, stop or check to this timer
    always_comb begin
        n_remaining = r_remaining;
        n_reload    = r_reload;
        n_flag      = r_flag;
        n_auto      = r_auto;
        if (i_cmd.tick) begin
            if (r_remaining != '0) begin
                if (r_remaining == PERIOD_W'(1)) begin
                    n_flag      = 1'b1;
                    n_remaining = r_auto ? r_reload : '0;
                end else begin
                    n_remaining = r_remaining - PERIOD_W'(1);
                end
            end
        end else if (i_cmd.start && i_sel) begin
            n_remaining = i_cmd.period;
            n_reload    = i_cmd.period;
            n_flag      = 1'b0;
            n_auto      = i_cmd.auto_reload;
        end else if (i_cmd.stop && i_sel) begin
            n_remaining = '0;
            n_flag      = 1'b0;
            n_auto      = 1'b0;
        end else if (i_cmd.check && i_sel) begin
            n_flag = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_reload    <= '0;
            r_flag      <= 1'b0;
            r_auto      <= 1'b0;
        end else begin
            r_remaining <= n_remaining;
            r_reload    <= n_reload;
            r_flag      <= n_flag;
            r_auto      <= n_auto;
        end
    end

    assign o_flag = r_flag;

endmodule

>>> rtl/core/stb_run_clock.sv
module stb_run_clock (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_tick,
    input  logic [stb_pkg::RUN_W-1:0] i_reference_time,
    output logic [stb_pkg::RUN_W-1:0] o_run_time_next,
    output logic [stb_pkg::RUN_W-1:0] o_elapsed
);
    import stb_pkg::*;

    logic [RUN_W-1:0] r_uptime, n_uptime;
    logic [RUN_W:0]   diff;

    // Advance the run-time counter, wrapping before the top value
    always_comb begin
        n_uptime = r_uptime;
        if (i_tick) begin
            if (r_uptime == RUN_TIME_WRAP - RUN_W'(1)) begin
                n_uptime = '0;
            end else begin
                n_uptime = r_uptime + RUN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uptime <= '0;
        end else begin
            r_uptime <= n_uptime;
        end
    end

    // Elapsed ticks: a borrow means the counter wrapped, which skips one value
    always_comb begin
        diff      = {1'b0, r_uptime} - {1'b0, i_reference_time};
        o_elapsed = diff[RUN_W] ? (diff[RUN_W-1:0] - RUN_W'(1)) : diff[RUN_W-1:0];
    end

    assign o_run_time_next = n_uptime;

endmodule

>>> rtl/core/soft_timer_bank.sv
// Channel | Handshake                | Beat contents
// input   | i_in_valid / o_in_ready  | i_opcode, i_timer_id, i_period, i_reference_time
// output  | o_out_valid / i_out_ready | o_expired, o_run_time, o_elapsed, o_bad_id
//
// One beat in and one beat out per cycle while the output is not stalled; an accepted
// beat goes into the input register, then through the timer cells and run clock into
// the result register, where the result becomes valid.
// Reset clears all timers and the run clock; no sweep follows.
// A stalled output holds the result register; one more beat waits in the input register.
`include "soft_timer_bank_assert.svh"

module soft_timer_bank #(
    parameter int NUM_TIMERS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [stb_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [stb_pkg::ID_W-1:0]     i_timer_id,
    input  logic [stb_pkg::PERIOD_W-1:0] i_period,
    input  logic [stb_pkg::RUN_W-1:0]    i_reference_time,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_expired,
    output logic [stb_pkg::RUN_W-1:0]    o_run_time,
    output logic [stb_pkg::RUN_W-1:0]    o_elapsed,
    output logic                         o_bad_id
);
    import stb_pkg::*;

    logic                r_in_valid;
    logic [OPCODE_W-1:0] r_opcode;
    logic [ID_W-1:0]     r_timer_id;
    logic [PERIOD_W-1:0] r_period;
    logic [RUN_W-1:0]    r_reference_time;

    logic                r_out_valid;
    logic                r_expired, n_expired;
    logic [RUN_W-1:0]    r_run_time;
    logic [RUN_W-1:0]    r_elapsed, n_elapsed;
    logic                r_bad_id, n_bad_id;

    logic                  advance;
    logic                  id_ok;
    t_cell_cmd             cmd;
    logic [NUM_TIMERS-1:0] sel;
    logic [NUM_TIMERS-1:0] flags;
    logic [RUN_W-1:0]      run_time_next;
    logic [RUN_W-1:0]      elapsed_now;

    // Move the held beat into the result register when that slot frees up
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Hold the accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_opcode         <= i_opcode;
            r_timer_id       <= i_timer_id;
            r_period         <= i_period;
            r_reference_time <= i_reference_time;
        end
    end

    assign id_ok = (r_timer_id < ID_W'(NUM_TIMERS));

    // Decode the operation into a cell command and the result fields
    always_comb begin
        cmd        = '0;
        cmd.period = r_period;
        n_expired  = 1'b0;
        n_elapsed  = '0;
        n_bad_id   = 1'b0;
        case (t_opcode'(r_opcode))
            OP_TICK: begin
                cmd.tick = advance;
            end
            OP_START_ONCE, OP_START_AUTO: begin
                if (id_ok) begin
                    cmd.start       = advance;
                    cmd.auto_reload = (t_opcode'(r_opcode) == OP_START_AUTO);
                end else begin
                    n_bad_id = 1'b1;
                end
            end
            OP_STOP: begin
                if (id_ok) begin
                    cmd.stop = advance;
                end else begin
                    n_bad_id = 1'b1;
                end
            end
            OP_CHECK: begin
                if (id_ok) begin
                    cmd.check = advance;
                    n_expired = |(flags & sel);
                end else begin
                    n_bad_id = 1'b1;
                end
            end
            OP_READ_TIME: begin
                n_elapsed = '0;
            end
            OP_ELAPSED: begin
                n_elapsed = elapsed_now;
            end
            default: begin
                n_elapsed = '0;
            end
        endcase
    end

    // Timer cells, one per timer, each selected by its own id
    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        assign sel[g] = (r_timer_id == ID_W'(g));

        stb_timer_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_sel   (sel[g]),
            .o_flag  (flags[g])
        );
    end

    stb_run_clock u_run_clock (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_tick           (cmd.tick),
        .i_reference_time (r_reference_time),
        .o_run_time_next  (run_time_next),
        .o_elapsed        (elapsed_now)
    );

    // Load the result beat, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_expired  <= n_expired;
            r_run_time <= run_time_next;
            r_elapsed  <= n_elapsed;
            r_bad_id   <= n_bad_id;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_expired   = r_expired;
    assign o_run_time  = r_run_time;
    assign o_elapsed   = r_elapsed;
    assign o_bad_id    = r_bad_id;

    `STB_ASSERT_NOW(a_run_time_below_wrap, r_out_valid, r_run_time != RUN_TIME_WRAP, "run time reached wrap value")
    `STB_ASSERT_NOW(a_expired_excludes_bad, r_out_valid, !(r_expired && r_bad_id), "expired set with bad id")
    `STB_ASSERT_NEXT(a_tick_moves_clock, advance && cmd.tick, r_run_time == $past(run_time_next), "tick result missing")
    `STB_ASSERT_NEXT(a_elapsed_only_on_op, advance && (t_opcode'(r_opcode) != OP_ELAPSED), r_elapsed == '0, "elapsed set by other op")
    `STB_ASSERT_NOW(a_empty_output_takes_beat, !r_out_valid, o_in_ready, "input stalled with empty output")

endmodule
